[hdl/ntc_pkg.sv]
// shared constants, table and types for the ntc adc to celsius core
package ntc_pkg;

    localparam int unsigned NTC_POINTS   = 11;
    localparam int unsigned NTC_SEGS     = NTC_POINTS - 1;
    localparam int unsigned ADC_W        = 10;
    localparam int unsigned TEMP_W       = 9;
    localparam int unsigned SEG_W        = 4;
    localparam int unsigned OFF_W        = 8;
    localparam int unsigned PROD_IN_W    = 12;
    localparam int unsigned RECIP_W      = 12;
    localparam int unsigned RECIP_SHIFT  = 16;
    localparam int unsigned PROD_W       = PROD_IN_W + RECIP_W;
    localparam int unsigned QUOT_W       = 5;
    localparam int unsigned QSPAN_W      = QUOT_W + OFF_W;
    localparam int unsigned RECIP_ONE    = 65536;

    typedef logic [ADC_W-1:0]         adc_t;
    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [SEG_W-1:0]         seg_t;
    typedef logic [OFF_W-1:0]         off_t;

    localparam adc_t NTC_CODE [NTC_POINTS] = '{
        10'd980, 10'd960, 10'd920, 10'd850, 10'd750, 10'd620,
        10'd480, 10'd360, 10'd260, 10'd180, 10'd120
    };

    localparam temp_t NTC_TEMP [NTC_POINTS] = '{
        -9'sd40, -9'sd20, 9'sd0, 9'sd20, 9'sd40, 9'sd60,
        9'sd80, 9'sd100, 9'sd120, 9'sd140, 9'sd160
    };

    // code span of each segment
    localparam off_t NTC_SPAN [NTC_SEGS] = '{
        8'd20, 8'd40, 8'd70, 8'd100, 8'd130, 8'd140, 8'd120, 8'd100, 8'd80, 8'd60
    };

    // floor of 2^16 over each span
    localparam logic [RECIP_W-1:0] NTC_RECIP [NTC_SEGS] = '{
        RECIP_W'(RECIP_ONE / 20),  RECIP_W'(RECIP_ONE / 40),
        RECIP_W'(RECIP_ONE / 70),  RECIP_W'(RECIP_ONE / 100),
        RECIP_W'(RECIP_ONE / 130), RECIP_W'(RECIP_ONE / 140),
        RECIP_W'(RECIP_ONE / 120), RECIP_W'(RECIP_ONE / 100),
        RECIP_W'(RECIP_ONE / 80),  RECIP_W'(RECIP_ONE / 60)
    };

    // per-stage load enables of the arithmetic pipe
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ntc_stage_en_t;

endpackage

[hdl/ntc_seg.sv]
// first pipe stage: segment search, code offset and base temperature
module ntc_seg
    import ntc_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  adc_t  adc_code,
    output seg_t  seg,
    output off_t  off,
    output temp_t t_base
);

    seg_t  seg_reg,  seg_next;
    off_t  off_reg,  off_next;
    temp_t tb_reg,   tb_next;
    logic  hit;
    adc_t  diff;

    always_comb
    begin
        hit      = 1'b0;
        seg_next = '0;
        diff     = '0;
        // walk downwards so the first bracketing segment wins
        for (int i = NTC_SEGS - 1; i >= 0; i--)
        begin
            if (adc_code >= NTC_CODE[i+1] && adc_code <= NTC_CODE[i])
            begin
                hit      = 1'b1;
                seg_next = SEG_W'(i);
            end
        end
        if (hit)
        begin
            diff     = NTC_CODE[seg_next] - adc_code;
            off_next = diff[OFF_W-1:0];
            tb_next  = NTC_TEMP[seg_next];
        end
        else if (adc_code > NTC_CODE[0])
        begin
            off_next = '0;
            tb_next  = NTC_TEMP[0];
        end
        else
        begin
            off_next = '0;
            tb_next  = NTC_TEMP[NTC_POINTS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_next;
            off_reg <= off_next;
            tb_reg  <= tb_next;
        end
    end

    assign seg    = seg_reg;
    assign off    = off_reg;
    assign t_base = tb_reg;

endmodule

[hdl/ntc_interp.sv]
// interpolation stages: scale, reciprocal multiply, quotient fix-up, add
module ntc_interp
    import ntc_pkg::*;
(
    input  logic          clk,
    input  ntc_stage_en_t en,
    input  seg_t          seg,
    input  off_t          off,
    input  temp_t         t_base,
    output temp_t         temp_celsius
);

    // stage 2
    logic [PROD_IN_W-1:0] p2_reg,     p2_next;
    logic [RECIP_W-1:0]   recip2_reg, recip2_next;
    off_t                 span2_reg,  span2_next;
    temp_t                tb2_reg;
    // stage 3
    logic [PROD_W-1:0]    prod3_reg,  prod3_next;
    logic [PROD_IN_W-1:0] p3_reg;
    off_t                 span3_reg;
    temp_t                tb3_reg;
    // stage 4
    logic [QUOT_W-1:0]    q4_reg,     q4_next;
    logic [QSPAN_W-1:0]   qs4_reg,    qs4_next;
    logic [PROD_IN_W-1:0] p4_reg;
    off_t                 span4_reg;
    temp_t                tb4_reg;
    // stage 5
    temp_t                temp5_reg,  temp5_next;
    logic [QSPAN_W-1:0]   rem;
    logic [QUOT_W-1:0]    q_fix;

    always_comb
    begin
        // off times 20 as shift and add
        p2_next     = (PROD_IN_W'(off) << 4) + (PROD_IN_W'(off) << 2);
        recip2_next = NTC_RECIP[seg];
        span2_next  = NTC_SPAN[seg];
        prod3_next  = PROD_W'(p2_reg) * PROD_W'(recip2_reg);
        q4_next     = prod3_reg[RECIP_SHIFT +: QUOT_W];
        qs4_next    = QSPAN_W'(q4_next) * QSPAN_W'(span3_reg);
        rem         = QSPAN_W'(p4_reg) - qs4_reg;
        // estimate is at most one short
        q_fix       = (rem >= QSPAN_W'(span4_reg)) ? q4_reg + QUOT_W'(1) : q4_reg;
        temp5_next  = tb4_reg + $signed({{(TEMP_W-QUOT_W){1'b0}}, q_fix});
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p2_reg     <= p2_next;
            recip2_reg <= recip2_next;
            span2_reg  <= span2_next;
            tb2_reg    <= t_base;
        end
        if (en.s3)
        begin
            prod3_reg <= prod3_next;
            p3_reg    <= p2_reg;
            span3_reg <= span2_reg;
            tb3_reg   <= tb2_reg;
        end
        if (en.s4)
        begin
            q4_reg    <= q4_next;
            qs4_reg   <= qs4_next;
            p4_reg    <= p3_reg;
            span4_reg <= span3_reg;
            tb4_reg   <= tb3_reg;
        end
        if (en.s5)
        begin
            temp5_reg <= temp5_next;
        end
    end

    assign temp_celsius = temp5_reg;

endmodule

[hdl/ntc_adc_to_celsius_core.sv]
// top level: ntc thermistor adc code to celsius, five-stage pipe
// an accepted input beat passes the seg, s2, s3, s4 and s5 registers to its output beat
// throughput: one beat per cycle through the five-stage pipe while the output is not stalled
// a stalled output holds each full stage with no empty stage after it; empty stages still fill
// reset clears the stage valid bits only; no table state to initialise
module ntc_adc_to_celsius_core
    import ntc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [9:0] adc_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [8:0] temp_celsius
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] v_reg, v_next;
    logic [STAGES-1:0] en;
    ntc_stage_en_t     stage_en;
    seg_t              seg;
    off_t              off;
    temp_t             t_base;
    temp_t             temp_celsius;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_axis_tvalid : v_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign stage_en.s2 = en[1];
    assign stage_en.s3 = en[2];
    assign stage_en.s4 = en[3];
    assign stage_en.s5 = en[4];

    ntc_seg u_seg (
        .clk      (clk),
        .en       (en[0]),
        .adc_code (s_axis_tdata[ADC_W-1:0]),
        .seg      (seg),
        .off      (off),
        .t_base   (t_base)
    );

    ntc_interp u_interp (
        .clk          (clk),
        .en           (stage_en),
        .seg          (seg),
        .off          (off),
        .t_base       (t_base),
        .temp_celsius (temp_celsius)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[STAGES-1];
    assign m_axis_tdata  = {{(16-TEMP_W){1'b0}}, temp_celsius};

endmodule

[verif/tb.sv]
// testbench for the ntc adc to celsius core: directed, random, back-pressure and full-rate tests
module tb;
    import ntc_pkg::*;

    localparam int CURVE_POINTS = 11;
    localparam int CURVE_CODE [CURVE_POINTS] = '{
        980, 960, 920, 850, 750, 620, 480, 360, 260, 180, 120
    };
    localparam int CURVE_TEMP [CURVE_POINTS] = '{
        -40, -20, 0, 20, 40, 60, 80, 100, 120, 140, 160
    };
    localparam int RANDOM_CODES    = 1730;
    localparam int FULL_RATE_CODES = 200;
    localparam int LONG_HOLD       = 60;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int PIPE_LATENCY    = 5;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [9:0] adc_code
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [8:0] temp_celsius

    temp_t expected_temps [$];
    int    mismatch_count = 0;
    bit    sender_idle_on = 1'b0;
    bit    receiver_idle_on = 1'b0;
    bit    long_hold_pending = 1'b0;

    ntc_adc_to_celsius_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // first bracketing segment wins, quotient truncated
    function automatic temp_t celsius_from_adc(input adc_t code);
        int code_i;
        code_i = int'(code);
        for (int seg = 0; seg < CURVE_POINTS - 1; seg++)
        begin
            if (code_i >= CURVE_CODE[seg+1] && code_i <= CURVE_CODE[seg])
            begin
                return temp_t'(CURVE_TEMP[seg] +
                    ((CURVE_CODE[seg] - code_i) * (CURVE_TEMP[seg+1] - CURVE_TEMP[seg])) /
                    (CURVE_CODE[seg] - CURVE_CODE[seg+1]));
            end
        end
        if (code_i > CURVE_CODE[0])
        begin
            return temp_t'(CURVE_TEMP[0]);
        end
        return temp_t'(CURVE_TEMP[CURVE_POINTS-1]);
    endfunction

    // input beats are predicted, output beats are checked in order
    always @(posedge clk)
    begin
        temp_t want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_temps.push_back(celsius_from_adc(adc_t'(s_axis_tdata[ADC_W-1:0])));
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_temps.size() == 0)
            begin
                $error("temp_celsius: expected none, actual %0d",
                    $signed(m_axis_tdata[TEMP_W-1:0]));
                mismatch_count++;
            end
            else
            begin
                want = expected_temps.pop_front();
                if (temp_t'(m_axis_tdata[TEMP_W-1:0]) !== want)
                begin
                    $error("temp_celsius: expected %0d, actual %0d", want,
                        $signed(m_axis_tdata[TEMP_W-1:0]));
                    mismatch_count++;
                end
                if (m_axis_tdata[15:TEMP_W] !== '0)
                begin
                    $error("tdata padding: expected 0, actual %0h", m_axis_tdata[15:TEMP_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (receiver_idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_code(input adc_t code);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, code};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_temps.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_temps.size() != 0)
        begin
            $error("temp_celsius: expected %0d more beats, actual none", expected_temps.size());
            mismatch_count++;
        end
    endtask

    task automatic test_table_edges();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int p = 0; p < CURVE_POINTS; p++)
        begin
            send_code(adc_t'(CURVE_CODE[p]));
        end
        send_code(adc_t'(0));
        send_code(adc_t'(1023));
        send_code(adc_t'(119));
        send_code(adc_t'(121));
        send_code(adc_t'(979));
        send_code(adc_t'(981));
        send_code(adc_t'(961));
        send_code(adc_t'(599));
        send_code(adc_t'(512));
    endtask

    task automatic test_random_codes();
        int code;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        for (int n = 0; n < RANDOM_CODES; n++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                code = $urandom_range(0, 1023);
            end
            else
            begin
                // near a table point
                code = CURVE_CODE[$urandom_range(0, CURVE_POINTS - 1)] +
                    $urandom_range(0, 6) - 3;
            end
            send_code(adc_t'(code));
        end
    endtask

    task automatic test_back_pressure();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        long_hold_pending = 1'b1;
        for (int n = 0; n < 30; n++)
        begin
            send_code(adc_t'($urandom_range(0, 1023)));
        end
        wait_results_drained();
        for (int n = 0; n < 20; n++)
        begin
            send_code(adc_t'($urandom_range(0, 1023)));
        end
    endtask

    task automatic test_full_rate();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int n = 0; n < FULL_RATE_CODES; n++)
        begin
            send_code(adc_t'($urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_edges();
        test_random_codes();
        test_back_pressure();
        test_full_rate();
        wait_results_drained();
        repeat (PIPE_LATENCY * 4) @(posedge clk);
        if (expected_temps.size() != 0)
        begin
            $error("temp_celsius: expected %0d more beats, actual none", expected_temps.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
